### design/tcw_pkg.sv
package tcw_pkg;

	localparam int POS_W = 11;
	localparam int ADDR_W = 3;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_SETC = 2'd2;
	localparam logic [1:0] KIND_READ = 2'd3;

	localparam logic [7:0] CODE_LF = 8'd10;
	localparam logic [7:0] CODE_CR = 8'd13;

	localparam logic REG_SCROLL_FILL_ATTR = 1'b0;
	localparam logic [7:0] FILL_ATTR_RESET = 8'd15;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_LF,
		OP_CR,
		OP_CLEAR,
		OP_SETC,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [7:0] code;
		logic [7:0] attr;
		logic [POS_W-1:0] position;
	} op_t;

	typedef struct packed {
		logic [POS_W-1:0] cursor;
		logic [7:0] read_code;
		logic [7:0] read_attr;
		logic past_end;
	} res_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

endpackage

### design/tcw_fifo.sv
module tcw_fifo #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [W-1:0] rdata,
	output logic empty
);

	logic [W-1:0] slot_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

### design/tcw_front.sv
module tcw_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] kind,
	input logic [7:0] code,
	input logic [7:0] attr,
	input logic [tcw_pkg::POS_W-1:0] position,
	input tcw_pkg::back_stat_t stat,
	output logic op_valid,
	output tcw_pkg::op_t op,
	input logic op_pop
);

	tcw_pkg::op_t op_in;
	logic q_full;
	logic q_empty;

	always_comb begin
		op_in.code = code;
		op_in.attr = attr;
		op_in.position = position;
		case (kind)
			tcw_pkg::KIND_WRITE: begin
				if (code == tcw_pkg::CODE_LF) begin
					op_in.kind = tcw_pkg::OP_LF;
				end else if (code == tcw_pkg::CODE_CR) begin
					op_in.kind = tcw_pkg::OP_CR;
				end else begin
					op_in.kind = tcw_pkg::OP_PUT;
				end
			end
			tcw_pkg::KIND_CLEAR: op_in.kind = tcw_pkg::OP_CLEAR;
			tcw_pkg::KIND_SETC: op_in.kind = tcw_pkg::OP_SETC;
			default: op_in.kind = tcw_pkg::OP_READ;
		endcase
	end

	// No request enters while the cell memory is being cleared after reset.
	assign full = q_full | stat.init_busy;
	assign op_valid = ~q_empty;

	tcw_fifo #(
		.W($bits(tcw_pkg::op_t))
	) u_opq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push & ~stat.init_busy),
		.wdata(op_in),
		.full(q_full),
		.pop(op_pop),
		.rdata(op),
		.empty(q_empty)
	);

endmodule

### design/tcw_back.sv
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	input tcw_pkg::op_t op,
	output logic op_pop,
	input logic [7:0] fill_attr,
	input logic res_full,
	output logic res_push,
	output tcw_pkg::res_t res,
	output tcw_pkg::back_stat_t stat
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int LAST = COLUMNS * (ROWS - 1);
	localparam int AW = $clog2(CELLS);
	localparam int CUR_W = ($clog2(CELLS + 1) > tcw_pkg::POS_W) ?
		$clog2(CELLS + 1) : tcw_pkg::POS_W;
	localparam int CL = $clog2(COLUMNS);
	localparam int SH = CUR_W + CL;
	localparam int MW = CUR_W + 2;
	localparam int PW = CUR_W + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(COLUMNS) - 64'd1) / 64'(COLUMNS));
	localparam logic [CUR_W-1:0] CELLS_C = CUR_W'(CELLS);
	localparam logic [CUR_W-1:0] LAST_C = CUR_W'(LAST);
	localparam logic [CUR_W-1:0] COLS_C = CUR_W'(COLUMNS);
	localparam logic [AW-1:0] K_LAST = AW'(LAST);
	localparam logic [AW-1:0] K_END = AW'(CELLS - 1);
	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
	localparam logic [CL-1:0] COL_MAX = CL'(COLUMNS - 1);

	typedef enum logic [6:0] {
		ST_INIT = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_CLEAR = 7'b0000100,
		ST_SCROLL = 7'b0001000,
		ST_BFILL = 7'b0010000,
		ST_READ = 7'b0100000,
		ST_SETC = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [AW-1:0] k_q, k_d;
	logic [CUR_W-1:0] cursor_q, cursor_d;
	logic [CL-1:0] col_q, col_d;
	logic [7:0] fattr_q, fattr_d;
	logic rd_zero_q, rd_zero_d;
	logic [PW-1:0] prod_q;

	logic [15:0] cell_mem [CELLS];
	logic [15:0] rdata_q;
	logic we;
	logic [AW-1:0] waddr;
	logic [15:0] wdata;
	logic ren;
	logic [AW-1:0] raddr;

	logic [CUR_W-1:0] posx;
	logic [CUR_W-1:0] sat_pos;
	logic [CUR_W-1:0] quot;
	logic [CUR_W-1:0] row_base;
	logic past;

	assign posx = CUR_W'(op.position);
	assign sat_pos = (posx > CELLS_C) ? CELLS_C : posx;
	assign quot = CUR_W'(prod_q >> SH);
	assign row_base = CUR_W'(quot * COLS_C);
	assign stat.init_busy = (state_q == ST_INIT);

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		cursor_d = cursor_q;
		col_d = col_q;
		fattr_d = fattr_q;
		rd_zero_d = rd_zero_q;
		op_pop = 1'b0;
		res_push = 1'b0;
		past = 1'b0;
		we = 1'b0;
		waddr = k_q;
		wdata = {fattr_q, 8'h00};
		ren = 1'b0;
		raddr = posx[AW-1:0];
		res.read_code = 8'h00;
		res.read_attr = 8'h00;
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				wdata = 16'h0000;
				if (k_q == K_END) begin
					k_d = '0;
					state_d = ST_IDLE;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (op_valid && !res_full) begin
					op_pop = 1'b1;
					case (op.kind)
						tcw_pkg::OP_PUT: begin
							res_push = 1'b1;
							if (cursor_q >= CELLS_C) begin
								cursor_d = CELLS_C;
								past = 1'b1;
							end else begin
								we = 1'b1;
								waddr = cursor_q[AW-1:0];
								wdata = {op.attr, op.code};
								cursor_d = cursor_q + 1'b1;
								col_d = (col_q == COL_MAX) ? '0 : col_q + 1'b1;
							end
						end
						tcw_pkg::OP_LF: begin
							if (cursor_q >= LAST_C) begin
								cursor_d = LAST_C;
								col_d = '0;
								k_d = '0;
								fattr_d = fill_attr;
								state_d = ST_SCROLL;
							end else begin
								cursor_d = cursor_q + COLS_C;
								res_push = 1'b1;
							end
						end
						tcw_pkg::OP_CR: begin
							cursor_d = cursor_q - CUR_W'(col_q);
							col_d = '0;
							res_push = 1'b1;
						end
						tcw_pkg::OP_CLEAR: begin
							cursor_d = '0;
							col_d = '0;
							k_d = '0;
							fattr_d = op.attr;
							state_d = ST_CLEAR;
						end
						tcw_pkg::OP_SETC: begin
							cursor_d = sat_pos;
							res_push = 1'b1;
							state_d = ST_SETC;
						end
						tcw_pkg::OP_READ: begin
							if (posx >= CELLS_C) begin
								rd_zero_d = 1'b1;
							end else begin
								rd_zero_d = 1'b0;
								ren = 1'b1;
							end
							state_d = ST_READ;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			ST_CLEAR, ST_BFILL: begin
				we = 1'b1;
				if (k_q == K_END) begin
					k_d = '0;
					res_push = 1'b1;
					state_d = ST_IDLE;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_SCROLL: begin
				// Read the cell one row below while the cell read last cycle lands a row up.
				if (k_q != K_LAST) begin
					ren = 1'b1;
					raddr = k_q + COLS_A;
					k_d = k_q + 1'b1;
				end else begin
					state_d = ST_BFILL;
				end
				if (k_q != '0) begin
					we = 1'b1;
					waddr = k_q - 1'b1;
					wdata = rdata_q;
				end
			end
			ST_READ: begin
				res_push = 1'b1;
				if (!rd_zero_q) begin
					res.read_code = rdata_q[7:0];
					res.read_attr = rdata_q[15:8];
				end
				state_d = ST_IDLE;
			end
			ST_SETC: begin
				col_d = CL'(cursor_q - row_base);
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.cursor = cursor_d[tcw_pkg::POS_W-1:0];
		res.past_end = past;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			k_q <= '0;
			cursor_q <= '0;
			col_q <= '0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			cursor_q <= cursor_d;
			col_q <= col_d;
		end
	end

	// The column of a newly set cursor comes from a reciprocal multiply.
	always_ff @(posedge clk) begin
		fattr_q <= fattr_d;
		rd_zero_q <= rd_zero_d;
		prod_q <= PW'(sat_pos) * PW'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			cell_mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= cell_mem[raddr];
		end
	end

endmodule

### design/text_console_writer.sv
// Channel   Handshake                   Beat
// request   push / full                 kind, code, attr, position
// result    empty / pop                 cursor, read_code, read_attr, past_end
// config    psel, penable, pwrite/pready scroll_fill_attr at byte address 0
//
// Printable characters, line feeds without scroll and carriage returns finish when taken.
// Set cursor and read cell pass through a second state; clear writes every cell in turn, a
// scrolling line feed moves each row up and fills the last row, via the single write port
// of the cell memory. After reset a clearing pass of all COLUMNS*ROWS cells holds full high.
// A two-beat queue on each side lets requests arrive and results wait independently.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] kind,
	input logic [7:0] code,
	input logic [7:0] attr,
	input logic [tcw_pkg::POS_W-1:0] position,
	output logic empty,
	input logic pop,
	output logic [tcw_pkg::POS_W-1:0] cursor,
	output logic [7:0] read_code,
	output logic [7:0] read_attr,
	output logic past_end,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tcw_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam logic [tcw_pkg::POS_W-1:0] CELLS_P = tcw_pkg::POS_W'(COLUMNS * ROWS);

	logic [7:0] fill_attr_q;
	tcw_pkg::back_stat_t stat;
	logic op_valid;
	tcw_pkg::op_t op;
	logic op_pop;
	logic res_full;
	logic res_push;
	tcw_pkg::res_t res;
	tcw_pkg::res_t res_out;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tcw_pkg::REG_SCROLL_FILL_ATTR) ?
		{24'h000000, fill_attr_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_attr_q <= tcw_pkg::FILL_ATTR_RESET;
		end else if (psel && penable && pwrite &&
				paddr[2] == tcw_pkg::REG_SCROLL_FILL_ATTR) begin
			fill_attr_q <= pwdata[7:0];
		end
	end

	tcw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.code(code),
		.attr(attr),
		.position(position),
		.stat(stat),
		.op_valid(op_valid),
		.op(op),
		.op_pop(op_pop)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op(op),
		.op_pop(op_pop),
		.fill_attr(fill_attr_q),
		.res_full(res_full),
		.res_push(res_push),
		.res(res),
		.stat(stat)
	);

	tcw_fifo #(
		.W($bits(tcw_pkg::res_t))
	) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(res_full),
		.pop(pop),
		.rdata(res_out),
		.empty(empty)
	);

	assign cursor = res_out.cursor;
	assign read_code = res_out.read_code;
	assign read_attr = res_out.read_attr;
	assign past_end = res_out.past_end;

`ifndef NO_ASSERTIONS
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_take_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> !res_full)
		else $error("request taken without room for its result");

	a_past_end_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.past_end) |-> res.cursor == CELLS_P)
		else $error("dropped write without the cursor at the screen end");

	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.init_busy |=> !stat.init_busy)
		else $error("clearing pass restarted without reset");
`endif

endmodule
